FILE: rtl/ddas_pkg.sv
`timescale 1ns / 1ps

package ddas_pkg;

  localparam int DDAS_POS_BITS = 32;

  localparam int IN_TDATA_BITS  = 104;
  localparam int IN_TUSER_BITS  = 2;
  localparam int OUT_TDATA_BITS = 120;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TICK = 2'd1,
    REQ_ZERO = 2'd2
  } req_e;

  // Per-beat commands from the top level to each axis.
  typedef struct packed {
    logic load;
    logic tick;
    logic clear;
    logic move_active;
  } ddas_ctl_t;

  // Per-axis status back to the top level.
  typedef struct packed {
    logic active;
    logic blocked;
    logic stepped;
  } ddas_stat_t;

endpackage

FILE: rtl/three_axis_dda_stepper.sv
`timescale 1ns / 1ps
// Three-axis DDA line generator for step/direction and two-pin coil drivers.
// Input stream (s_*): tuser carries the request kind (load, tick, zero) and
// tdata carries three target positions and the six limit switch levels.
// Every accepted beat yields exactly one result beat on m_*, carrying the
// step and direction masks, coil phases, busy/done, blocked axes and the
// current positions after that request.
// Results are registered (in the skid stage under a stall); one input beat is
// taken every cycle while the skid stage is empty. All three axes update in
// the cycle of acceptance, so the per-axis add/compare sets the clock period.
// When m_tready is low, one further beat is taken into a skid stage and then
// s_tready drops until the output drains.
// The cfg channel writes limit_active_low (always ready); write it only
// while no result is pending.
// Reset clears positions, targets and counters, sets all directions up,
// puts the coils at phase 0, ends any move and empties the output stages.
module three_axis_dda_stepper import ddas_pkg::*; #(
  parameter int POS_BITS = DDAS_POS_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // target_x, target_y, target_z, limit_switches, zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // req_type
  input  logic [IN_TUSER_BITS-1:0]  s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // step_mask, dir_mask, phase_x, phase_y, phase_z, busy_res, done_res,
  // limit_mask, pos_x, pos_y, pos_z, zero pad
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data
);

  logic              limit_active_low;
  logic              move_active;
  logic              move_active_next;
  logic [POS_BITS:0] major;
  logic [POS_BITS:0] major_new;
  logic              accept;
  logic [5:0]        sw;
  logic              any_active;
  logic              done;
  logic [OUT_TDATA_BITS-1:0] res;

  ddas_ctl_t         ctl;
  ddas_stat_t        stat      [3];
  logic [POS_BITS:0] delta_new [3];
  logic signed [POS_BITS-1:0] pos_next [3];
  logic [2:0]        dir_next;
  logic [1:0]        phase_next [3];
  logic [2:0]        step_mask;
  logic [2:0]        limit_mask;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;
  assign sw        = s_tdata[101:96] ^ {6{limit_active_low}};

  always_comb begin
    ctl = '0;
    ctl.move_active = move_active;
    if (accept) begin
      unique case (s_tuser)
        REQ_LOAD: ctl.load  = 1'b1;
        REQ_TICK: ctl.tick  = 1'b1;
        REQ_ZERO: ctl.clear = 1'b1;
        default:  ctl = ctl;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ddas_axis #(.POS_BITS(POS_BITS)) u_axis (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .target     ($signed(s_tdata[32*i +: 32])),
      .sw_min     (sw[2*i]),
      .sw_max     (sw[2*i+1]),
      .major      (major),
      .delta_new  (delta_new[i]),
      .stat       (stat[i]),
      .pos_next   (pos_next[i]),
      .dir_next   (dir_next[i]),
      .phase_next (phase_next[i])
    );
    assign step_mask[i]  = stat[i].stepped;
    assign limit_mask[i] = ctl.tick & stat[i].blocked;
  end

  always_comb begin
    major_new = delta_new[0];
    if (delta_new[1] > major_new) major_new = delta_new[1];
    if (delta_new[2] > major_new) major_new = delta_new[2];

    any_active = stat[0].active | stat[1].active | stat[2].active;
    done       = ctl.tick & move_active & ~any_active;

    move_active_next = move_active;
    priority if (ctl.load) begin
      move_active_next = 1'b1;
    end else if (ctl.clear || done) begin
      move_active_next = 1'b0;
    end

    res = {7'b0, 32'(pos_next[2]), 32'(pos_next[1]), 32'(pos_next[0]), limit_mask,
           done, move_active_next, phase_next[2], phase_next[1], phase_next[0],
           dir_next, step_mask};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_active_low <= 1'b0;
      move_active      <= 1'b0;
      major            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_active_low <= cfg_data;
      end
      move_active <= move_active_next;
      if (ctl.load) begin
        major <= major_new;
      end else if (ctl.clear) begin
        major <= '0;
      end
    end
  end

  ddas_out_buf #(.WIDTH(OUT_TDATA_BITS)) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: rtl/ddas_axis.sv
`timescale 1ns / 1ps

module ddas_axis import ddas_pkg::*; #(
  parameter int POS_BITS = DDAS_POS_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ddas_ctl_t                  ctl,
  input  logic signed [31:0]         target,
  input  logic                       sw_min,
  input  logic                       sw_max,
  input  logic        [POS_BITS:0]   major,
  output logic        [POS_BITS:0]   delta_new,
  output ddas_stat_t                 stat,
  output logic signed [POS_BITS-1:0] pos_next,
  output logic                       dir_next,
  output logic        [1:0]          phase_next
);

  localparam int EW = POS_BITS + 3;

  logic signed [POS_BITS-1:0] pos;
  logic signed [POS_BITS-1:0] tgt;
  logic        [POS_BITS:0]   delta;
  logic signed [EW-1:0]       err;
  logic                       dir;
  logic        [1:0]          phase;

  logic signed [POS_BITS-1:0] tgt_next;
  logic        [POS_BITS:0]   delta_next;
  logic signed [EW-1:0]       err_next;

  logic signed [POS_BITS-1:0] tgt_in;
  logic signed [POS_BITS:0]   span;
  logic signed [EW-1:0]       sum;
  logic                       short_of;
  logic                       trig;
  logic                       step_ok;

  // The error counter is kept offset by floor(major/2), so a load clears it
  // to zero and a step happens once it rises above that half.
  always_comb begin
    tgt_in    = POS_BITS'(target);
    span      = $signed({tgt_in[POS_BITS-1], tgt_in}) - $signed({pos[POS_BITS-1], pos});
    delta_new = span[POS_BITS] ? (POS_BITS+1)'(-span) : (POS_BITS+1)'(span);

    short_of     = pos != tgt;
    trig         = dir ? sw_max : sw_min;
    stat.active  = ctl.move_active & short_of & ~trig;
    stat.blocked = ctl.move_active & short_of & trig;

    sum     = err + $signed({2'b00, delta});
    step_ok = ctl.tick & stat.active & (sum > $signed({3'b000, major[POS_BITS:1]}));
    stat.stepped = step_ok;

    pos_next   = pos;
    tgt_next   = tgt;
    delta_next = delta;
    err_next   = err;
    dir_next   = dir;
    phase_next = phase;

    priority if (ctl.load) begin
      tgt_next   = tgt_in;
      delta_next = delta_new;
      err_next   = '0;
      dir_next   = ~span[POS_BITS];
    end else if (ctl.clear) begin
      pos_next   = '0;
      tgt_next   = '0;
      delta_next = '0;
      err_next   = '0;
      dir_next   = 1'b1;
    end else if (ctl.tick && stat.active) begin
      if (step_ok) begin
        err_next = sum - $signed({2'b00, major});
        pos_next = dir ? pos + POS_BITS'(1) : pos - POS_BITS'(1);
        // Gray sequence on the two coil pins, forward or backward.
        phase_next = dir ? {phase[0], ~phase[1]} : {~phase[0], phase[1]};
      end else begin
        err_next = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      tgt   <= '0;
      delta <= '0;
      err   <= '0;
      dir   <= 1'b1;
      phase <= '0;
    end else begin
      pos   <= pos_next;
      tgt   <= tgt_next;
      delta <= delta_next;
      err   <= err_next;
      dir   <= dir_next;
      phase <= phase_next;
    end
  end

endmodule

FILE: rtl/ddas_out_buf.sv
`timescale 1ns / 1ps

module ddas_out_buf import ddas_pkg::*; #(
  parameter int WIDTH = OUT_TDATA_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             out_free;

  // One beat may land in the skid stage while the output is stalled; the
  // input side only closes once that stage is occupied.
  assign in_ready = ~skid_valid;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!out_free && in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: rtl/ddas_chk.sv
`timescale 1ns / 1ps

module ddas_chk import ddas_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata
);

  // A held result beat must not change under a stall.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // The input side only closes when a result is waiting at the output.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A finished move reports idle, and a stepping tick keeps the move busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13] || m_tdata[2:0] != 3'b000) |->
      (m_tdata[13] != m_tdata[12]) && !(m_tdata[13] && m_tdata[2:0] != 3'b000))
    else $error("done, busy and step flags disagree");

  // An axis cannot both step and be held at a limit on the same tick.
  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] & m_tdata[16:14]) == 3'b000)
    else $error("axis stepped and blocked at once");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind three_axis_dda_stepper ddas_chk u_ddas_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/three_axis_dda_stepper_tb.sv
`timescale 1ns / 1ps

module three_axis_dda_stepper_tb;
  import ddas_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_MOVE_TICKS = 80;

  typedef struct {
    logic [2:0]  step_mask;
    logic [2:0]  dir_mask;
    logic [1:0]  phase_x;
    logic [1:0]  phase_y;
    logic [1:0]  phase_z;
    logic        busy;
    logic        done;
    logic [2:0]  limit_mask;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } motion_res_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic [IN_TUSER_BITS-1:0]  s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_data = 1'b0;

  // Predicted machine state.
  int      axis_pos[3];
  int      axis_tgt[3];
  longint  axis_delta[3];
  longint  axis_err[3];
  longint  major_delta;
  bit      axis_up[3] = '{1'b1, 1'b1, 1'b1};
  bit [1:0] coil_ph[3];
  bit      move_on;
  bit      low_active;

  motion_res_t motion_q[$];

  int errors;
  int items_sent;
  int results_seen;
  int step_results;
  int done_results;
  int limit_results;
  int cycle_count;
  int burst_left;
  bit gaps_on = 1'b1;
  logic [11:0] rx_phase = '0;

  three_axis_dda_stepper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               motion_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure: always ready, sparse random stalls, a regular
  // stall comb, and heavy random stalls, taken in turn as rx_phase[9:8] counts up.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (rx_phase[3:0] < 4'd10);
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  function automatic motion_res_t predict_motion(logic [1:0] req, int tx, int ty, int tz,
                                                 logic [5:0] sw);
    motion_res_t r;
    logic [5:0] trig;
    int t[3];
    longint d;
    logic [2:0] stp;
    logic [2:0] lim;
    bit any;
    bit up;
    t[0] = tx;
    t[1] = ty;
    t[2] = tz;
    trig = low_active ? ~sw : sw;
    stp = '0;
    lim = '0;
    r.done = 1'b0;
    case (req)
      REQ_LOAD: begin
        major_delta = 0;
        for (int i = 0; i < 3; i++) begin
          d = longint'(t[i]) - longint'(axis_pos[i]);
          axis_tgt[i] = t[i];
          axis_up[i] = (d >= 0);
          axis_delta[i] = (d < 0) ? -d : d;
          if (axis_delta[i] > major_delta) major_delta = axis_delta[i];
        end
        for (int i = 0; i < 3; i++) axis_err[i] = -(major_delta / 2);
        move_on = 1'b1;
      end
      REQ_TICK: begin
        if (move_on) begin
          any = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (axis_pos[i] != axis_tgt[i]) begin
              up = axis_up[i];
              // Switch bit 2*axis is the min switch, the next one the max switch.
              if (trig[2*i + up]) begin
                lim[i] = 1'b1;
              end else begin
                any = 1'b1;
                axis_err[i] += axis_delta[i];
                if (axis_err[i] > 0) begin
                  case (coil_ph[i])
                    2'b00: coil_ph[i] = up ? 2'b01 : 2'b10;
                    2'b01: coil_ph[i] = up ? 2'b11 : 2'b00;
                    2'b11: coil_ph[i] = up ? 2'b10 : 2'b01;
                    default: coil_ph[i] = up ? 2'b00 : 2'b11;
                  endcase
                  axis_err[i] -= major_delta;
                  axis_pos[i] += up ? 1 : -1;
                  stp[i] = 1'b1;
                end
              end
            end
          end
          if (!any) begin
            move_on = 1'b0;
            r.done = 1'b1;
          end
        end
      end
      REQ_ZERO: begin
        for (int i = 0; i < 3; i++) begin
          axis_pos[i] = 0;
          axis_tgt[i] = 0;
          axis_delta[i] = 0;
          axis_err[i] = 0;
          axis_up[i] = 1'b1;
        end
        major_delta = 0;
        move_on = 1'b0;
      end
      default: ;
    endcase
    r.step_mask  = stp;
    r.dir_mask   = {axis_up[2], axis_up[1], axis_up[0]};
    r.phase_x    = coil_ph[0];
    r.phase_y    = coil_ph[1];
    r.phase_z    = coil_ph[2];
    r.busy       = move_on;
    r.limit_mask = lim;
    r.pos_x      = axis_pos[0];
    r.pos_y      = axis_pos[1];
    r.pos_z      = axis_pos[2];
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    motion_res_t got;
    motion_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.step_mask  = m_tdata[2:0];
      got.dir_mask   = m_tdata[5:3];
      got.phase_x    = m_tdata[7:6];
      got.phase_y    = m_tdata[9:8];
      got.phase_z    = m_tdata[11:10];
      got.busy       = m_tdata[12];
      got.done       = m_tdata[13];
      got.limit_mask = m_tdata[16:14];
      got.pos_x      = m_tdata[48:17];
      got.pos_y      = m_tdata[80:49];
      got.pos_z      = m_tdata[112:81];
      results_seen++;
      if (got.step_mask != 0) step_results++;
      if (got.done) done_results++;
      if (got.limit_mask != 0) limit_results++;
      if (motion_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
      end else begin
        want = motion_q.pop_front();
        compare_field("step_mask", want.step_mask, got.step_mask);
        compare_field("dir_mask", want.dir_mask, got.dir_mask);
        compare_field("phase_x", want.phase_x, got.phase_x);
        compare_field("phase_y", want.phase_y, got.phase_y);
        compare_field("phase_z", want.phase_z, got.phase_z);
        compare_field("busy_res", want.busy, got.busy);
        compare_field("done_res", want.done, got.done);
        compare_field("limit_mask", want.limit_mask, got.limit_mask);
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("pos_z", want.pos_z, got.pos_z);
      end
    end
  end

  // Sends one request beat; valid stays high across beats within a burst.
  task automatic send_req(logic [1:0] req, int tx, int ty, int tz, logic [5:0] sw);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, sw, tz, ty, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    motion_q.push_back(predict_motion(req, tx, ty, tz, sw));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit_polarity(bit value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    low_active = value;
  endtask

  function automatic logic [5:0] quiet_switches();
    return low_active ? 6'h3f : 6'h00;
  endfunction

  function automatic int near_target(int p);
    return p + int'($urandom_range(0, 40)) - 20;
  endfunction

  task automatic tick_until_stopped(int max_ticks);
    int n;
    n = 0;
    while (move_on && n < max_ticks) begin
      send_req(REQ_TICK, 0, 0, 0, quiet_switches());
      n++;
    end
  endtask

  task automatic test_idle_requests();
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_UNUSED, 32'h7fffffff, 32'h80000000, -1, 6'h3f);
    send_req(REQ_ZERO, -1, -1, -1, 6'h2a);
    send_req(REQ_TICK, 0, 0, 0, 6'h15);
  endtask

  task automatic test_extreme_targets();
    send_req(REQ_LOAD, 32'h7fffffff, 32'h80000000, 0, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    // Every switch triggered: both moving axes are blocked and the move ends.
    send_req(REQ_TICK, 0, 0, 0, 6'h3f);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_ZERO, 0, 0, 0, 6'h00);
  endtask

  task automatic test_short_moves();
    // A load with no distance still starts a move that the next tick ends.
    send_req(REQ_LOAD, 0, 0, 0, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_LOAD, 3, -2, 1, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    // A new load in the middle of a move restarts from where the axes are.
    send_req(REQ_LOAD, -1, 4, 0, 6'h00);
    tick_until_stopped(10);
  endtask

  task automatic test_active_low_limits();
    write_limit_polarity(1'b1);
    send_req(REQ_LOAD, 5, -5, 2, 6'h00);
    send_req(REQ_TICK, 0, 0, 0, 6'h3f);
    send_req(REQ_TICK, 0, 0, 0, 6'h00);
    send_req(REQ_ZERO, 0, 0, 0, 6'h3f);
    send_req(REQ_LOAD, -3, 2, 0, 6'h3f);
    tick_until_stopped(10);
    write_limit_polarity(1'b0);
  endtask

  task automatic run_random_move();
    int t[3];
    int n;
    logic [5:0] sw;
    for (int i = 0; i < 3; i++)
      t[i] = ($urandom_range(0, 9) == 0) ? int'($urandom()) : near_target(axis_pos[i]);
    send_req(REQ_LOAD, t[0], t[1], t[2], 6'($urandom_range(0, 63)));
    n = 0;
    while (move_on && n < MAX_MOVE_TICKS) begin
      if ($urandom_range(0, 49) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_req(REQ_ZERO, 0, 0, 0, quiet_switches());
        else
          send_req(REQ_LOAD, near_target(axis_pos[0]), near_target(axis_pos[1]),
                   near_target(axis_pos[2]), quiet_switches());
      end else begin
        sw = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : quiet_switches();
        send_req(REQ_TICK, 0, 0, 0, sw);
      end
      n++;
    end
  endtask

  task automatic test_random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
      if (pick < 3)
        drain_results();
      else if (pick < 75)
        run_random_move();
      else
        send_req(2'($urandom_range(0, 3)), int'($urandom()), int'($urandom()),
                 int'($urandom()), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_requests();
    test_extreme_targets();
    test_short_moves();
    test_active_low_limits();
    test_random_traffic(600);
    write_limit_polarity(1'b1);
    test_random_traffic(400);
    write_limit_polarity(1'b0);
    test_random_traffic(300);
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d results under both switch polarities.",
             items_sent, results_seen);
    $display("Results with steps: %0d, moves ended: %0d, limit stops seen: %0d.",
             step_results, done_results, limit_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: three_axis_dda_stepper.f
rtl/ddas_pkg.sv
rtl/ddas_axis.sv
rtl/ddas_out_buf.sv
rtl/three_axis_dda_stepper.sv
rtl/ddas_chk.sv
bench/three_axis_dda_stepper_tb.sv
